// File: rtl/ryc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryc_pkg
// Shared constants, types and coefficient tables for the RGB/YUV converter.
// ----------------------------------------------------------------------------
package ryc_pkg;

    // Channel format: unsigned fraction, all ones means 1.0
    localparam int    CH_BITS = 16;
    localparam longint CH_FULL = (longint'(1) << CH_BITS) - 1;

    // Denominators of the luma, chroma and inverse outputs
    localparam longint DEN_Y = 64'sd255000;
    localparam longint DEN_C = 64'sd100000;
    localparam longint DEN_I = 64'sd44000000;
    localparam int     DEN_W = 26;

    // Signed numerator, clamped remainder and coefficient widths
    localparam int NUM_W  = CH_BITS + 29;
    localparam int REM_W  = CH_BITS + DEN_W;
    localparam int COEF_W = 28;

    // Reciprocal scale: a clamped remainder stays below 2^shift, so the
    // truncated reciprocal leaves the quotient at most one short
    localparam int     SH_Y  = $clog2(DEN_Y) + CH_BITS;
    localparam int     SH_C  = $clog2(DEN_C) + CH_BITS;
    localparam int     SH_I  = $clog2(DEN_I) + CH_BITS;
    localparam longint RCP_Y = (longint'(1) << SH_Y) / DEN_Y;
    localparam longint RCP_C = (longint'(1) << SH_C) / DEN_C;
    localparam longint RCP_I = (longint'(1) << SH_I) / DEN_I;
    localparam int     RCP_W = CH_BITS + 1;

    // Pipeline: multiply, two add stages, clamp, then four reciprocal divide stages
    localparam int MAC_STG = 4;
    localparam int DIV_STG = 4;
    localparam int NSTG    = MAC_STG + DIV_STG;

    // Direction register codes
    localparam logic DIR_RGB2YUV = 1'b0;
    localparam logic DIR_YUV2RGB = 1'b1;

    // Output lane codes
    localparam logic [1:0] LANE_A = 2'd0;
    localparam logic [1:0] LANE_B = 2'd1;
    localparam logic [1:0] LANE_C = 2'd2;

    // Three coefficients, term for chan_a in the low slice
    typedef logic [3*COEF_W-1:0] t_coef_set;

    // Control bundle from the pipeline controller to the lanes
    typedef struct packed {
        logic [NSTG-1:0] en;       // stage load enables
        logic [NSTG-2:0] dir;      // direction of the request held in each stage
        logic            cfg_dir;  // direction for a request entering now
    } t_ctl;

    // Coefficients applied to chan_a, chan_b, chan_c
    function automatic t_coef_set coef_of(input logic dir, input logic [1:0] lane);
        t_coef_set c;
        c = '0;
        unique case ({dir, lane})
            {DIR_RGB2YUV, LANE_A}: c = {COEF_W'(25080), COEF_W'(129140), COEF_W'(65780)};
            {DIR_RGB2YUV, LANE_B}: c = {COEF_W'(43600), COEF_W'(-28886), COEF_W'(-14713)};
            {DIR_RGB2YUV, LANE_C}: c = {COEF_W'(-10001), COEF_W'(-51499), COEF_W'(61500)};
            {DIR_YUV2RGB, LANE_A}: c = {COEF_W'(50152520), COEF_W'(0), COEF_W'(51000000)};
            {DIR_YUV2RGB, LANE_B}: c = {COEF_W'(-25546400), COEF_W'(-17364600),
                                        COEF_W'(51000000)};
            {DIR_YUV2RGB, LANE_C}: c = {COEF_W'(0), COEF_W'(89412840), COEF_W'(51000000)};
            default:               c = '0;
        endcase
        return c;
    endfunction

    // Denominator of each output
    function automatic longint div_of(input logic dir, input logic [1:0] lane);
        longint d;
        d = DEN_I;
        unique case ({dir, lane})
            {DIR_RGB2YUV, LANE_A}: d = DEN_Y;
            {DIR_RGB2YUV, LANE_B}: d = DEN_C;
            {DIR_RGB2YUV, LANE_C}: d = DEN_C;
            default:               d = DEN_I;
        endcase
        return d;
    endfunction

    // Truncated reciprocal of each denominator
    function automatic longint rcp_of(input logic dir, input logic [1:0] lane);
        longint m;
        m = RCP_I;
        unique case ({dir, lane})
            {DIR_RGB2YUV, LANE_A}: m = RCP_Y;
            {DIR_RGB2YUV, LANE_B}: m = RCP_C;
            {DIR_RGB2YUV, LANE_C}: m = RCP_C;
            default:               m = RCP_I;
        endcase
        return m;
    endfunction

    // Right shift that goes with each reciprocal
    function automatic int shift_of(input logic dir, input logic [1:0] lane);
        int s;
        s = SH_I;
        unique case ({dir, lane})
            {DIR_RGB2YUV, LANE_A}: s = SH_Y;
            {DIR_RGB2YUV, LANE_B}: s = SH_C;
            {DIR_RGB2YUV, LANE_C}: s = SH_C;
            default:               s = SH_I;
        endcase
        return s;
    endfunction

    // Constant term times full scale, plus half a denominator for rounding
    function automatic logic signed [NUM_W-1:0] bias_of(input logic dir,
                                                         input logic [1:0] lane);
        longint b;
        b = 64'sd0;
        unique case ({dir, lane})
            {DIR_RGB2YUV, LANE_A}: b = 64'sd16000;
            {DIR_RGB2YUV, LANE_B}: b = 64'sd50000;
            {DIR_RGB2YUV, LANE_C}: b = 64'sd50000;
            {DIR_YUV2RGB, LANE_A}: b = -64'sd28276260;
            {DIR_YUV2RGB, LANE_B}: b = 64'sd18255500;
            {DIR_YUV2RGB, LANE_C}: b = -64'sd47906420;
            default:               b = 64'sd0;
        endcase
        return NUM_W'(b * CH_FULL + (div_of(dir, lane) >>> 1));
    endfunction

endpackage

// File: rtl/ryc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryc_ctrl
// Direction register, stage valid bits, load enables and alpha delay line.
// ----------------------------------------------------------------------------
module ryc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ryc_pkg::CH_BITS-1:0] i_alpha_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ryc_pkg::CH_BITS-1:0] o_alpha_out,
    output ryc_pkg::t_ctl               o_ctl
);

    logic                        r_dir;
    logic [ryc_pkg::NSTG-1:0]    r_vld;
    logic [ryc_pkg::NSTG-1:0]    n_vld;
    logic [ryc_pkg::NSTG-1:0]    w_en;
    logic [ryc_pkg::NSTG-2:0]    r_dir_p;
    logic [ryc_pkg::CH_BITS-1:0] r_alpha [ryc_pkg::NSTG];

    // Hold the direction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= ryc_pkg::DIR_RGB2YUV;
        end else if (i_cfg_we) begin
            r_dir <= i_cfg_wdata;
        end
    end

    // A stage loads when its own or some later slot is empty or the output drains
    for (genvar k = 0; k < ryc_pkg::NSTG; k++) begin : g_en
        assign w_en[k] = ~(&r_vld[ryc_pkg::NSTG-1:k]) | ~i_out_stall;
    end

    // Advance valid bits, filling bubbles
    assign n_vld = (w_en & {r_vld[ryc_pkg::NSTG-2:0], i_in_valid}) | (~w_en & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Carry direction and alpha along with each request
    for (genvar k = 0; k < ryc_pkg::NSTG; k++) begin : g_pipe
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en[0]) begin
                    r_alpha[0] <= i_alpha_in;
                    r_dir_p[0] <= r_dir;
                end
            end
        end else if (k < ryc_pkg::NSTG - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_alpha[k] <= r_alpha[k-1];
                    r_dir_p[k] <= r_dir_p[k-1];
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_alpha[k] <= r_alpha[k-1];
                end
            end
        end
    end

    assign o_in_stall  = ~w_en[0];
    assign o_out_valid = r_vld[ryc_pkg::NSTG-1];
    assign o_alpha_out = r_alpha[ryc_pkg::NSTG-1];

    assign o_ctl.en      = w_en;
    assign o_ctl.dir     = r_dir_p;
    assign o_ctl.cfg_dir = r_dir;

endmodule

// File: rtl/ryc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryc_mac
// One output lane: coefficient products, sum with bias, range clamp.
// Emits the rounded numerator ready for the divider.
// ----------------------------------------------------------------------------
module ryc_mac (
    input  logic                        i_clk,
    input  logic [1:0]                  i_lane,
    input  ryc_pkg::t_ctl               i_ctl,
    input  logic [ryc_pkg::CH_BITS-1:0] i_chan_a,
    input  logic [ryc_pkg::CH_BITS-1:0] i_chan_b,
    input  logic [ryc_pkg::CH_BITS-1:0] i_chan_c,
    output logic [ryc_pkg::REM_W-1:0]   o_rem
);

    localparam int NW = ryc_pkg::NUM_W;
    localparam int CW = ryc_pkg::COEF_W;

    ryc_pkg::t_coef_set   w_coef;
    logic signed [NW-1:0] r_p0, r_p1, r_p2;
    logic signed [NW-1:0] r_s01, r_s2b;
    logic signed [NW-1:0] r_num;
    logic [ryc_pkg::REM_W-1:0] r_rem;
    logic [ryc_pkg::REM_W-1:0] n_rem;
    logic                 w_zero;
    logic                 w_over;

    // Stage 0: multiply each channel by its coefficient
    assign w_coef = ryc_pkg::coef_of(i_ctl.cfg_dir, i_lane);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_p0 <= NW'($signed(w_coef[CW-1:0])      * $signed({1'b0, i_chan_a}));
            r_p1 <= NW'($signed(w_coef[2*CW-1:CW])   * $signed({1'b0, i_chan_b}));
            r_p2 <= NW'($signed(w_coef[3*CW-1:2*CW]) * $signed({1'b0, i_chan_c}));
        end
    end

    // Stage 1: pairwise sums, bias folded into the third term
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_s01 <= r_p0 + r_p1;
            r_s2b <= r_p2 + ryc_pkg::bias_of(i_ctl.dir[0], i_lane);
        end
    end

    // Stage 2: full rounded numerator
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_num <= r_s01 + r_s2b;
        end
    end

    // Stage 3: clamp; negative gives zero, overflow gives a remainder that
    // divides to full scale
    assign w_zero = r_num <= NW'(ryc_pkg::div_of(i_ctl.dir[2], i_lane) >>> 1);
    assign w_over = r_num >= NW'(ryc_pkg::div_of(i_ctl.dir[2], i_lane) <<< ryc_pkg::CH_BITS);

    always_comb begin
        if (w_zero) begin
            n_rem = '0;
        end else if (w_over) begin
            n_rem = ryc_pkg::REM_W'(
                (ryc_pkg::div_of(i_ctl.dir[2], i_lane) <<< ryc_pkg::CH_BITS) - 1);
        end else begin
            n_rem = r_num[ryc_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

// File: rtl/ryc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryc_div
// Pipelined division by the lane's constant denominator: split reciprocal
// multiply, shift to an estimate that is at most one short, then one
// compare against the next multiple of the denominator.
// ----------------------------------------------------------------------------
module ryc_div (
    input  logic                        i_clk,
    input  logic [1:0]                  i_lane,
    input  ryc_pkg::t_ctl               i_ctl,
    input  logic [ryc_pkg::REM_W-1:0]   i_rem,
    output logic [ryc_pkg::CH_BITS-1:0] o_quot
);

    localparam int RW = ryc_pkg::REM_W;
    localparam int QW = ryc_pkg::CH_BITS;
    localparam int MS = ryc_pkg::MAC_STG;
    localparam int MW = ryc_pkg::RCP_W;
    localparam int DW = ryc_pkg::DEN_W;
    localparam int LW = RW / 2;
    localparam int HW = RW - LW;
    localparam int PW = RW + MW;

    logic [MW-1:0]    w_rcp;
    logic [HW+MW-1:0] r_ph;
    logic [LW+MW-1:0] r_pl;
    logic [RW-1:0]    r_r0, r_r1, r_r2;
    logic [PW-1:0]    w_sum;
    logic [QW-1:0]    w_q0;
    logic [QW-1:0]    r_q0, r_q1;
    logic [DW-1:0]    w_den;
    logic [RW-1:0]    r_lim;
    logic [QW-1:0]    r_q;

    // Stage 0: multiply high and low halves of the remainder by the reciprocal
    assign w_rcp = MW'(ryc_pkg::rcp_of(i_ctl.dir[MS-1], i_lane));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[MS]) begin
            r_ph <= (HW+MW)'(i_rem[RW-1:LW]) * (HW+MW)'(w_rcp);
            r_pl <= (LW+MW)'(i_rem[LW-1:0]) * (LW+MW)'(w_rcp);
            r_r0 <= i_rem;
        end
    end

    // Stage 1: join the partial products and shift down to the estimate
    assign w_sum = (PW'(r_ph) << LW) + PW'(r_pl);
    assign w_q0  = QW'(w_sum >> ryc_pkg::shift_of(i_ctl.dir[MS], i_lane));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[MS+1]) begin
            r_q0 <= w_q0;
            r_r1 <= r_r0;
        end
    end

    // Stage 2: next multiple of the denominator above the estimate
    assign w_den = DW'(ryc_pkg::div_of(i_ctl.dir[MS+1], i_lane));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[MS+2]) begin
            r_lim <= RW'(r_q0) * RW'(w_den) + RW'(w_den);
            r_q1  <= r_q0;
            r_r2  <= r_r1;
        end
    end

    // Stage 3: bump the estimate when the remainder reaches that multiple
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[MS+3]) begin
            r_q <= r_q1 + QW'(r_r2 >= r_lim);
        end
    end

    assign o_quot = r_q;

endmodule

// File: rtl/rgb_yuv_color_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_yuv_color_converter
// Per-pixel BT.601 RGB to YUV and YUV to RGB converter on unsigned
// fraction channels, with clamping and round-half-up; alpha passes through.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Payload
//  input    i_in_valid / o_in_stall   i_chan_a, i_chan_b, i_chan_c, i_alpha_in
//  output   o_out_valid / i_out_stall o_out_a, o_out_b, o_out_c, o_alpha_out
//  config   i_cfg_we                  i_cfg_wdata (direction)
//
//  One pixel per cycle while o_in_stall is low; 4 multiply/add/clamp stages and
//  4 divide stages (split reciprocal multiply, shift, multiple, compare).
//  Reset clears the stage valid bits and sets direction to RGB to YUV.
//  Each stage moves when it or any later stage is empty or the output is taken;
//  o_in_stall rises only with all 8 stages full and the output stalled.
// ----------------------------------------------------------------------------
module rgb_yuv_color_converter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ryc_pkg::CH_BITS-1:0] i_chan_a,
    input  logic [ryc_pkg::CH_BITS-1:0] i_chan_b,
    input  logic [ryc_pkg::CH_BITS-1:0] i_chan_c,
    input  logic [ryc_pkg::CH_BITS-1:0] i_alpha_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ryc_pkg::CH_BITS-1:0] o_out_a,
    output logic [ryc_pkg::CH_BITS-1:0] o_out_b,
    output logic [ryc_pkg::CH_BITS-1:0] o_out_c,
    output logic [ryc_pkg::CH_BITS-1:0] o_alpha_out
);

    ryc_pkg::t_ctl               w_ctl;
    logic [ryc_pkg::REM_W-1:0]   w_rem_a, w_rem_b, w_rem_c;

    // Pipeline control and alpha delay
    ryc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_alpha_in  (i_alpha_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_alpha_out (o_alpha_out),
        .o_ctl       (w_ctl)
    );

    // Numerator lanes
    ryc_mac u_mac_a (
        .i_clk (i_clk), .i_lane (ryc_pkg::LANE_A), .i_ctl (w_ctl),
        .i_chan_a (i_chan_a), .i_chan_b (i_chan_b), .i_chan_c (i_chan_c),
        .o_rem (w_rem_a)
    );

    ryc_mac u_mac_b (
        .i_clk (i_clk), .i_lane (ryc_pkg::LANE_B), .i_ctl (w_ctl),
        .i_chan_a (i_chan_a), .i_chan_b (i_chan_b), .i_chan_c (i_chan_c),
        .o_rem (w_rem_b)
    );

    ryc_mac u_mac_c (
        .i_clk (i_clk), .i_lane (ryc_pkg::LANE_C), .i_ctl (w_ctl),
        .i_chan_a (i_chan_a), .i_chan_b (i_chan_b), .i_chan_c (i_chan_c),
        .o_rem (w_rem_c)
    );

    // Divider lanes
    ryc_div u_div_a (
        .i_clk (i_clk), .i_lane (ryc_pkg::LANE_A), .i_ctl (w_ctl),
        .i_rem (w_rem_a), .o_quot (o_out_a)
    );

    ryc_div u_div_b (
        .i_clk (i_clk), .i_lane (ryc_pkg::LANE_B), .i_ctl (w_ctl),
        .i_rem (w_rem_b), .o_quot (o_out_b)
    );

    ryc_div u_div_c (
        .i_clk (i_clk), .i_lane (ryc_pkg::LANE_C), .i_ctl (w_ctl),
        .i_rem (w_rem_c), .o_quot (o_out_c)
    );

`ifndef NO_ASSERTIONS
    // Input stalls only when the pipeline is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while pipeline can move");

    // A stage that loads implies every earlier stage loads too
    a_en_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &(w_ctl.en[ryc_pkg::NSTG-2:0] | ~w_ctl.en[ryc_pkg::NSTG-1:1]))
        else $error("stage enables out of order");

    // An empty output slot lets every stage load, so the input is not stalled
    a_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> (w_ctl.en == '1))
        else $error("stage held with empty output slot");

    // Nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule

// File: tb/rgb_yuv_color_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_yuv_color_converter_tb
// Self-checking bench for the RGB/YUV pixel converter. A directed table covers
// black, white, primaries, clamping at both ends and alternating bit patterns
// in each direction. Random phases follow, alternating the direction register.
// Every accepted pixel is predicted in exact integer arithmetic and compared,
// in order, with the pixels the block returns. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module rgb_yuv_color_converter_tb;
    import ryc_pkg::*;

    typedef logic [CH_BITS-1:0] chan_t;

    typedef struct packed {
        chan_t a;
        chan_t b;
        chan_t c;
        chan_t alpha;
    } pixel_t;

    // One directed request: direction, input pixel, optional hand-typed result
    typedef struct packed {
        logic   dir;
        pixel_t px;
        logic   typed;
        pixel_t res;
    } row_t;

    localparam int     N_ROWS       = 22;
    localparam int     RANDOM_ITEMS = 200;
    localparam chan_t  FULL         = chan_t'(CH_FULL);
    localparam pixel_t NONE         = '0;

    localparam row_t DIRECTED [N_ROWS] = '{
        // RGB to YUV: black and white read straight off the scale factors
        '{DIR_RGB2YUV, '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
          1'b1, '{16'd4112, 16'd32768, 16'd32768, 16'h0000}},
        '{DIR_RGB2YUV, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
          1'b1, '{16'd60652, 16'd32768, 16'd32768, 16'hFFFF}},
        // Primaries and secondaries push chroma past one and below zero
        '{DIR_RGB2YUV, '{16'hFFFF, 16'h0000, 16'h0000, 16'h1234}, 1'b0, NONE},
        '{DIR_RGB2YUV, '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000}, 1'b0, NONE},
        '{DIR_RGB2YUV, '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b0, NONE},
        '{DIR_RGB2YUV, '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000}, 1'b0, NONE},
        '{DIR_RGB2YUV, '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h7FFF}, 1'b0, NONE},
        '{DIR_RGB2YUV, '{16'h8000, 16'h8000, 16'h8000, 16'h0001}, 1'b0, NONE},
        '{DIR_RGB2YUV, '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, NONE},
        '{DIR_RGB2YUV, '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, NONE},
        '{DIR_RGB2YUV, '{16'h0001, 16'h0001, 16'h0001, 16'hFFFE}, 1'b0, NONE},
        // YUV to RGB: negative sums, sums above one, neutral gray range ends
        '{DIR_YUV2RGB, '{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NONE},
        '{DIR_YUV2RGB, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, NONE},
        '{DIR_YUV2RGB, '{16'hFFFF, 16'h0000, 16'h0000, 16'h4321}, 1'b0, NONE},
        '{DIR_YUV2RGB, '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0F0F}, 1'b0, NONE},
        '{DIR_YUV2RGB, '{16'd4112, 16'h8000, 16'h8000, 16'hF0F0}, 1'b0, NONE},
        '{DIR_YUV2RGB, '{16'd60652, 16'h8000, 16'h8000, 16'h00FF}, 1'b0, NONE},
        '{DIR_YUV2RGB, '{16'h8000, 16'h0000, 16'hFFFF, 16'hFF00}, 1'b0, NONE},
        '{DIR_YUV2RGB, '{16'h8000, 16'hFFFF, 16'h0000, 16'h5A5A}, 1'b0, NONE},
        '{DIR_YUV2RGB, '{16'hAAAA, 16'h5555, 16'hAAAA, 16'hA5A5}, 1'b0, NONE},
        '{DIR_YUV2RGB, '{16'h5555, 16'hAAAA, 16'h5555, 16'h3C3C}, 1'b0, NONE},
        '{DIR_YUV2RGB, '{16'hFFFE, 16'h8000, 16'h7FFF, 16'hC3C3}, 1'b0, NONE}
    };

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    logic  i_cfg_wdata;
    logic  i_in_valid;
    logic  o_in_stall;
    chan_t i_chan_a;
    chan_t i_chan_b;
    chan_t i_chan_c;
    chan_t i_alpha_in;
    logic  o_out_valid;
    logic  i_out_stall;
    chan_t o_out_a;
    chan_t o_out_b;
    chan_t o_out_c;
    chan_t o_alpha_out;

    pixel_t expected_pixels[$];
    logic   cur_dir;
    int     idle_pct;
    int     mismatch_count;

    rgb_yuv_color_converter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_chan_a    (i_chan_a),
        .i_chan_b    (i_chan_b),
        .i_chan_c    (i_chan_c),
        .i_alpha_in  (i_alpha_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_a     (o_out_a),
        .o_out_b     (o_out_b),
        .o_out_c     (o_out_c),
        .o_alpha_out (o_alpha_out)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Round a positive fraction to the nearest code, halves up; clamp to [0, FULL]
    function automatic chan_t round_to_code(input longint num, input longint den);
        longint q;
        if (num <= 0) begin
            return '0;
        end
        q = (num + den / 2) / den;
        if (q > CH_FULL) begin
            q = CH_FULL;
        end
        return chan_t'(q);
    endfunction

    // Exact integer conversion of one pixel in the given direction
    function automatic pixel_t convert_pixel(input logic dir, input pixel_t px);
        pixel_t res;
        longint a, b, c;
        longint luma, ybase, du, dv;
        a = longint'(px.a);
        b = longint'(px.b);
        c = longint'(px.c);
        res.alpha = px.alpha;
        if (dir == DIR_RGB2YUV) begin
            luma  = 299 * a + 587 * b + 114 * c;
            res.a = round_to_code(luma * 220 + 16000 * CH_FULL, 255000);
            res.b = round_to_code(50000 * CH_FULL - 14713 * a - 28886 * b + 43600 * c,
                                  100000);
            res.c = round_to_code(50000 * CH_FULL + 61500 * a - 51499 * b - 10001 * c,
                                  100000);
        end else begin
            ybase = (255 * a - 16 * CH_FULL) * 200000;
            du    = (2 * b - CH_FULL) * 220;
            dv    = (2 * c - CH_FULL) * 220;
            res.a = round_to_code(ybase + 113983 * dv, 44000000);
            res.b = round_to_code(ybase - 39465 * du - 58060 * dv, 44000000);
            res.c = round_to_code(ybase + 203211 * du, 44000000);
        end
        return res;
    endfunction

    // Channel value biased toward zero, full scale and one half
    function automatic chan_t random_chan();
        int pick;
        pick = $urandom_range(15);
        case (pick)
            0:       return '0;
            1:       return FULL;
            2:       return chan_t'($urandom_range(32775, 32760));
            default: return chan_t'($urandom);
        endcase
    endfunction

    // Random pixel; in YUV mode half of them stay near the legal YUV range
    function automatic pixel_t random_pixel(input logic dir);
        pixel_t px;
        px.alpha = chan_t'($urandom);
        if (dir == DIR_YUV2RGB && $urandom_range(1) == 0) begin
            px.a = chan_t'($urandom_range(60652, 4112));
            px.b = chan_t'($urandom_range(48768, 16768));
            px.c = chan_t'($urandom_range(48768, 16768));
        end else begin
            px.a = random_chan();
            px.b = random_chan();
            px.c = random_chan();
        end
        return px;
    endfunction

    // Offer one pixel after random idle cycles; record its result on acceptance
    task automatic send_pixel(input pixel_t px, input logic typed, input pixel_t typed_res);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_chan_a   <= px.a;
        i_chan_b   <= px.b;
        i_chan_c   <= px.c;
        i_alpha_in <= px.alpha;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        expected_pixels.push_back(typed ? typed_res : convert_pixel(cur_dir, px));
    endtask

    // Drain the pipeline, then write the direction register
    task automatic write_direction(input logic dir);
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= dir;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_dir = dir;
    endtask

    task automatic check_field(input string name, input chan_t exp_val, input chan_t act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Stall the output side at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < idle_pct);
    end

    // Compare each returned pixel with the oldest prediction
    always @(posedge i_clk) begin
        pixel_t exp_px;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("out: unexpected pixel a=%0d b=%0d c=%0d alpha=%0d",
                       o_out_a, o_out_b, o_out_c, o_alpha_out);
                mismatch_count++;
            end else begin
                exp_px = expected_pixels.pop_front();
                check_field("out_a", exp_px.a, o_out_a);
                check_field("out_b", exp_px.b, o_out_b);
                check_field("out_c", exp_px.c, o_out_c);
                check_field("alpha_out", exp_px.alpha, o_alpha_out);
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain, report
    initial begin
        mismatch_count = 0;
        idle_pct       = 6;
        cur_dir        = DIR_RGB2YUV;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= DIR_RGB2YUV;
        i_in_valid     <= 1'b0;
        i_chan_a       <= '0;
        i_chan_b       <= '0;
        i_chan_c       <= '0;
        i_alpha_in     <= '0;
        i_out_stall    <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, switching direction where the table does
        write_direction(DIR_RGB2YUV);
        for (int i = 0; i < N_ROWS; i++) begin
            if (DIRECTED[i].dir != cur_dir) begin
                write_direction(DIRECTED[i].dir);
            end
            send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].res);
        end

        // Random phases; the second one runs with no idling at all
        for (int ph = 0; ph < 4; ph++) begin
            write_direction((ph % 2 == 0) ? DIR_RGB2YUV : DIR_YUV2RGB);
            idle_pct = (ph == 1) ? 0 : 6;
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                send_pixel(random_pixel(cur_dir), 1'b0, NONE);
            end
        end

        // Drain, then keep watching the output to catch stray pixels
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (NSTG + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS rgb_yuv_color_converter");
        end else begin
            $display("FAIL rgb_yuv_color_converter");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAIL rgb_yuv_color_converter");
        $finish;
    end

endmodule
